// ===== rtl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// Types and codes shared by the minimum-tracking stack modules.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam logic        KIND_PUSH = 1'b0;
    localparam logic        KIND_POP  = 1'b1;

    localparam logic [1:0]  STATUS_OK         = 2'd0;
    localparam logic [1:0]  STATUS_PUSH_FULL  = 2'd1;
    localparam logic [1:0]  STATUS_POP_EMPTY  = 2'd2;

    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
    } mts_req_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic signed [31:0] minimum;
        logic [8:0]         fill_count;
        logic [1:0]         status;
    } mts_rsp_t;

    typedef struct packed {
        logic push;
        logic pop;
    } mts_shift_t;

endpackage

// ===== rtl/mts_cell.sv =====
// ----------------------------------------------------------------------------
// mts_cell
// One stack entry: takes the word above on a push, the word below on a pop.
// ----------------------------------------------------------------------------
module mts_cell
    import mts_pkg::*;
(
    input  logic               clk,
    input  mts_shift_t         shift,
    input  logic signed [31:0] from_above,
    input  logic signed [31:0] from_below,
    output logic signed [31:0] word
);

    logic signed [31:0] word_reg;
    logic signed [31:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (shift.push)
        begin
            word_next = from_above;
        end
        else if (shift.pop)
        begin
            word_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== rtl/mts_cell_chain.sv =====
// ----------------------------------------------------------------------------
// mts_cell_chain
// Row of stack cells; cell 0 is the top, words move down on push, up on pop.
// ----------------------------------------------------------------------------
module mts_cell_chain
    import mts_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic               clk,
    input  mts_shift_t         shift,
    input  logic signed [31:0] push_value,
    output logic signed [31:0] top_word,
    output logic signed [31:0] next_word
);

    logic signed [31:0] cell_word [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [31:0] above;
            logic signed [31:0] below;

            if (i == 0)
            begin : g_top
                assign above = push_value;
            end
            else
            begin : g_mid
                assign above = cell_word[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_bottom
                assign below = cell_word[i];
            end
            else
            begin : g_inner
                assign below = cell_word[i+1];
            end

            mts_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .from_above (above),
                .from_below (below),
                .word       (cell_word[i])
            );
        end
    endgenerate

    assign top_word  = cell_word[0];
    assign next_word = cell_word[1];

endmodule

// ===== rtl/min_tracking_stack_core.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// Signed 32-bit stack that reports its current minimum after every beat.
//
//   port group   role     payload     accepted when
//   req          input    mts_req_t   req_valid && !req_stall
//   rsp          output   mts_rsp_t   rsp_valid && !rsp_stall
//
// One beat a cycle while req_stall is low: a push or pop that succeeds
// shifts the data row, and the minima row as needed, at the accepting edge,
// which registers its response too; the beat is offered from the next cycle.
// Reset clears the counts and the response valid; the minimum is the top of
// the minima row, or the largest value while that row is empty. Cell
// contents are left as they are.
// req_stall rises only while a response is held and rsp_stall is high.
// ----------------------------------------------------------------------------
module min_tracking_stack_core
    import mts_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  mts_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output mts_rsp_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [CW-1:0]      data_count_reg, data_count_next;
    logic [CW-1:0]      min_count_reg, min_count_next;
    logic               rsp_valid_reg, rsp_valid_next;
    mts_rsp_t           rsp_reg, rsp_next;

    logic               accept;
    mts_shift_t         data_shift;
    mts_shift_t         min_shift;
    logic signed [31:0] data_top, data_second;
    logic signed [31:0] min_top, min_second;
    logic signed [31:0] current_min;
    logic signed [31:0] new_min;
    logic [CW+8:0]      count_wide;

    assign req_stall   = rsp_valid_reg && rsp_stall;
    assign accept      = req_valid && !req_stall;
    assign current_min = (min_count_reg != '0) ? min_top : WORD_MAX;

    mts_cell_chain #(.DEPTH(DEPTH)) u_data_chain (
        .clk        (clk),
        .shift      (data_shift),
        .push_value (req.value),
        .top_word   (data_top),
        .next_word  (data_second)
    );

    mts_cell_chain #(.DEPTH(DEPTH)) u_min_chain (
        .clk        (clk),
        .shift      (min_shift),
        .push_value (req.value),
        .top_word   (min_top),
        .next_word  (min_second)
    );

    always_comb
    begin
        data_shift       = '0;
        min_shift        = '0;
        data_count_next  = data_count_reg;
        min_count_next   = min_count_reg;
        new_min          = current_min;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;

        if (accept)
        begin
            rsp_next.popped_value = '0;
            rsp_next.status       = STATUS_OK;
            if (req.kind == KIND_PUSH)
            begin
                if (data_count_reg >= DEPTH_C)
                begin
                    rsp_next.status = STATUS_PUSH_FULL;
                end
                else
                begin
                    data_shift.push = 1'b1;
                    data_count_next = data_count_reg + CW'(1);
                    if (req.value <= current_min)
                    begin
                        new_min = req.value;
                        if (min_count_reg < DEPTH_C)
                        begin
                            min_shift.push = 1'b1;
                            min_count_next = min_count_reg + CW'(1);
                        end
                    end
                end
            end
            else
            begin
                if (data_count_reg == '0)
                begin
                    rsp_next.status = STATUS_POP_EMPTY;
                end
                else
                begin
                    data_shift.pop        = 1'b1;
                    data_count_next       = data_count_reg - CW'(1);
                    rsp_next.popped_value = data_top;
                    if (data_top == current_min)
                    begin
                        if (min_count_reg > CW'(1))
                        begin
                            min_shift.pop  = 1'b1;
                            min_count_next = min_count_reg - CW'(1);
                            new_min        = min_second;
                        end
                        else
                        begin
                            min_shift.pop  = (min_count_reg != '0);
                            min_count_next = '0;
                            new_min        = WORD_MAX;
                        end
                    end
                end
            end
            rsp_next.minimum = new_min;
            rsp_valid_next   = 1'b1;
        end

        count_wide          = {9'd0, data_count_next};
        rsp_next.fill_count = count_wide[8:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_count_reg  <= '0;
            min_count_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            data_count_reg  <= data_count_next;
            min_count_reg   <= min_count_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== tb/min_tracking_stack_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_tracking_stack_core_test
// Self-checking bench for the minimum-tracking stack core.
//
// A short table of directed operations runs first. It covers pops on an empty
// stack, pushes of both signed extremes, duplicated minima and draining back
// to empty. A random phase follows. It mixes walks of pushes and pops with runs
// that fill the stack past full or drain it past empty. Each accepted request
// beat is stepped through a local model of both stacks, and the reply beats
// are compared field by field in order. Both handshakes idle and stall at
// random, with calm stretches that do neither.
// ----------------------------------------------------------------------------
module min_tracking_stack_core_test;
    import mts_pkg::*;

    localparam int                 DEPTH       = 256;
    localparam int                 ITEMS       = 1550;
    localparam int                 IDLE_LIMIT  = 2000;
    localparam logic signed [31:0] WORD_MIN    = 32'sh8000_0000;
    localparam mts_rsp_t           NO_REPLY    = '0;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
        logic               typed;
        mts_rsp_t           want;
    } op_row_t;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    mts_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    mts_rsp_t rsp;

    logic signed [31:0] stack_mem [DEPTH];
    logic signed [31:0] min_mem [DEPTH];
    int                 stack_fill;
    int                 min_fill;
    logic signed [31:0] cur_min;

    mts_rsp_t reply_q [$];
    int       mismatch_count;
    int       items_sent;
    int       idle_cycles;
    bit       calm;

    op_row_t plan [24] = '{
        '{KIND_POP,  32'sd0,  1'b1, '{32'sd0, WORD_MAX, 9'd0, STATUS_POP_EMPTY}},
        '{KIND_PUSH, WORD_MAX, 1'b1, '{32'sd0, WORD_MAX, 9'd1, STATUS_OK}},
        '{KIND_PUSH, WORD_MAX, 1'b1, '{32'sd0, WORD_MAX, 9'd2, STATUS_OK}},
        '{KIND_POP,  32'sd0,  1'b1, '{WORD_MAX, WORD_MAX, 9'd1, STATUS_OK}},
        '{KIND_PUSH, WORD_MIN, 1'b1, '{32'sd0, WORD_MIN, 9'd2, STATUS_OK}},
        '{KIND_PUSH, WORD_MIN, 1'b1, '{32'sd0, WORD_MIN, 9'd3, STATUS_OK}},
        '{KIND_PUSH, 32'sd0,  1'b1, '{32'sd0, WORD_MIN, 9'd4, STATUS_OK}},
        '{KIND_POP,  32'sd0,  1'b1, '{32'sd0, WORD_MIN, 9'd3, STATUS_OK}},
        '{KIND_POP,  32'sd0,  1'b1, '{WORD_MIN, WORD_MIN, 9'd2, STATUS_OK}},
        '{KIND_POP,  32'sd0,  1'b1, '{WORD_MIN, WORD_MAX, 9'd1, STATUS_OK}},
        '{KIND_PUSH, -32'sd1, 1'b0, NO_REPLY},
        '{KIND_PUSH, 32'sd5,  1'b0, NO_REPLY},
        '{KIND_PUSH, -32'sd1, 1'b0, NO_REPLY},
        '{KIND_PUSH, -32'sd2, 1'b0, NO_REPLY},
        '{KIND_POP,  32'sh7FFF_0000, 1'b0, NO_REPLY},
        '{KIND_POP,  -32'sd1, 1'b0, NO_REPLY},
        '{KIND_POP,  32'sd0,  1'b0, NO_REPLY},
        '{KIND_POP,  32'sd0,  1'b0, NO_REPLY},
        '{KIND_POP,  32'sd0,  1'b1, '{WORD_MAX, WORD_MAX, 9'd0, STATUS_OK}},
        '{KIND_POP,  WORD_MIN, 1'b1, '{32'sd0, WORD_MAX, 9'd0, STATUS_POP_EMPTY}},
        '{KIND_PUSH, 32'sh5555_5555, 1'b0, NO_REPLY},
        '{KIND_PUSH, 32'shAAAA_AAAA, 1'b0, NO_REPLY},
        '{KIND_POP,  32'sd0,  1'b0, NO_REPLY},
        '{KIND_POP,  32'sd0,  1'b0, NO_REPLY}
    };

    min_tracking_stack_core #(
        .DEPTH (DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Step both stacks by one operation and return the reply it should give.
    function automatic mts_rsp_t step_min_stack(mts_req_t r);
        mts_rsp_t o;
        o = '0;
        o.status = STATUS_OK;
        if (r.kind == KIND_PUSH)
        begin
            if (stack_fill >= DEPTH)
            begin
                o.status = STATUS_PUSH_FULL;
            end
            else
            begin
                stack_mem[stack_fill] = r.value;
                stack_fill++;
                if (r.value <= cur_min)
                begin
                    cur_min = r.value;
                    if (min_fill < DEPTH)
                    begin
                        min_mem[min_fill] = r.value;
                        min_fill++;
                    end
                end
            end
        end
        else
        begin
            if (stack_fill == 0)
            begin
                o.status = STATUS_POP_EMPTY;
            end
            else
            begin
                stack_fill--;
                o.popped_value = stack_mem[stack_fill];
                if (o.popped_value == cur_min)
                begin
                    if (min_fill > 0)
                        min_fill--;
                    cur_min = (min_fill > 0) ? min_mem[min_fill - 1] : WORD_MAX;
                end
            end
        end
        o.minimum    = cur_min;
        o.fill_count = stack_fill[8:0];
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode) inside
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            [2:4]:   return 32'($urandom_range(0, 16)) - 32'sd8;
            5:       return cur_min - 32'($urandom_range(0, 2));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(logic k, logic signed [31:0] v, logic typed, mts_rsp_t want);
        mts_req_t r;
        mts_rsp_t got;
        int       gap;
        r.kind  = k;
        r.value = v;
        gap     = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        got = step_min_stack(r);
        reply_q.push_back(typed ? want : got);
        items_sent++;
    endtask

    // Request side: directed table, then random sessions.
    initial
    begin
        int sel;
        int len;
        int pop_pct;
        int session;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        stack_fill     = 0;
        min_fill       = 0;
        cur_min        = WORD_MAX;
        mismatch_count = 0;
        items_sent     = 0;
        calm           = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_op(plan[i].kind, plan[i].value, plan[i].typed, plan[i].want);

        session = 0;
        while (items_sent < ITEMS)
        begin
            sel  = $urandom_range(0, 15);
            calm = ($urandom_range(0, 3) == 0);
            if (session == 0 || sel == 0)
            begin
                while (stack_fill < DEPTH)
                    send_op(KIND_PUSH, pick_value(), 1'b0, NO_REPLY);
                repeat ($urandom_range(1, 3))
                    send_op(KIND_PUSH, pick_value(), 1'b0, NO_REPLY);
            end
            else if (sel == 1)
            begin
                while (stack_fill > 0)
                    send_op(KIND_POP, $urandom, 1'b0, NO_REPLY);
                repeat ($urandom_range(1, 3))
                    send_op(KIND_POP, $urandom, 1'b0, NO_REPLY);
            end
            else
            begin
                len     = $urandom_range(20, 80);
                pop_pct = $urandom_range(25, 70);
                repeat (len)
                    send_op(($urandom_range(0, 99) < pop_pct) ? KIND_POP : KIND_PUSH,
                            pick_value(), 1'b0, NO_REPLY);
            end
            session++;
        end

        calm = 1'b0;
        @(negedge clk);
        req_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("** min_tracking_stack_core: PASSED **");
        else
            $display("** min_tracking_stack_core: FAILED **");
        $finish;
    end

    // Reply side stall: runs of ready cycles broken by holds.
    initial
    begin
        int run;
        int hold;
        rsp_stall = 1'b0;
        forever
        begin
            run  = $urandom_range(1, 12);
            hold = pick_gap();
            repeat (run)
            begin
                @(negedge clk);
                rsp_stall <= 1'b0;
            end
            repeat (hold)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        mts_rsp_t exp_rsp;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (reply_q.size() == 0)
            begin
                $error("reply beat with nothing outstanding");
                mismatch_count++;
            end
            else
            begin
                exp_rsp = reply_q.pop_front();
                if (rsp.popped_value !== exp_rsp.popped_value)
                begin
                    $error("popped_value: expected %0d, got %0d",
                           exp_rsp.popped_value, rsp.popped_value);
                    mismatch_count++;
                end
                if (rsp.minimum !== exp_rsp.minimum)
                begin
                    $error("minimum: expected %0d, got %0d", exp_rsp.minimum, rsp.minimum);
                    mismatch_count++;
                end
                if (rsp.fill_count !== exp_rsp.fill_count)
                begin
                    $error("fill_count: expected %0d, got %0d",
                           exp_rsp.fill_count, rsp.fill_count);
                    mismatch_count++;
                end
                if (rsp.status !== exp_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** min_tracking_stack_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        idle_cycles = 0;
    end

endmodule

// ===== filelist.f =====
rtl/mts_pkg.sv
rtl/mts_cell.sv
rtl/mts_cell_chain.sv
rtl/min_tracking_stack_core.sv
tb/min_tracking_stack_core_test.sv
